// File: src/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Types and constants used by the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int FRAME_W = 12;
    localparam int MAX_FRAMES = 1 << FRAME_W;

    // one map word covers 64 frames
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_MARK  = 2'd2
    } func_t;

    // input item
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] page_number;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic               ok;
    } out_item_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_FIND = 2'd1,
        ST_MOD  = 2'd2
    } state_t;

    // position of the lowest set bit of a map word
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: src/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator
// Free-frame bitmap in a 64-bit-wide RAM with per-word summary bits.
// ----------------------------------------------------------------------------
// Steps: IDLE takes the input, FIND reads the map word, MOD modifies it, writes it
// back on a hit and registers the result; a new item waits for that read-modify-write
// through the single RAM. A waiting result holds MOD, stalling write-back and result.
// Reset: synchronous active-low aresetn clears the word valid and summary bits
// at once, so every frame reads as used; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator
    import pfba_pkg::*;
#(
    parameter int FRAMES = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // frames above the page field can never be freed, so they are not stored
    localparam int EFF    = (FRAMES > MAX_FRAMES) ? MAX_FRAMES : FRAMES;
    localparam int DEPTH  = (EFF + WORD_W - 1) / WORD_W;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t             state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [FRAME_W-1:0] page_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [DEPTH-1:0]   vld_reg, vld_next;
    logic [DEPTH-1:0]   sum_reg, sum_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               out_free;
    logic [IDX_W-1:0]   sum_enc;
    logic [IDX_W-1:0]   page_idx;
    logic               page_in_range;
    logic               ram_rd_en;
    logic               ram_wr_en;
    logic [WORD_W-1:0]  ram_rd_data;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  new_word;
    logic [WORD_W-1:0]  bit_mask;
    logic [BIT_W-1:0]   bit_sel;
    logic               is_alloc;

    assign out_free = !out_valid_reg || m_ready;
    assign is_alloc = (func_reg == FUNC_ALLOC);

    // lowest word with any free frame
    always_comb begin
        sum_enc = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (sum_reg[i]) begin
                sum_enc = IDX_W'(i);
            end
        end
    end

    // word index and range check of the requested frame
    assign page_idx      = page_reg[IDX_W+BIT_W-1:BIT_W];
    assign page_in_range = ({1'b0, page_reg} < (FRAME_W + 1)'(EFF));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND: state_next = ST_MOD;
            ST_MOD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_FIND: ram_rd_en = 1'b1;
            ST_MOD:  ram_wr_en = out_free && hit_reg;
            default: ;
        endcase
    end

    // target word and validity of the operation
    always_comb begin
        idx_next = idx_reg;
        hit_next = hit_reg;
        if (state_reg == ST_FIND) begin
            if (is_alloc) begin
                idx_next = sum_enc;
                hit_next = |sum_reg;
            end else begin
                idx_next = page_idx;
                hit_next = page_in_range &&
                           (func_reg == FUNC_FREE || func_reg == FUNC_MARK);
            end
        end
    end

    // modify the fetched word; never-written words read as all used
    always_comb begin
        word     = vld_reg[idx_reg] ? ram_rd_data : '0;
        bit_sel  = is_alloc ? lowest_set(word) : page_reg[BIT_W-1:0];
        bit_mask = WORD_W'(1) << bit_sel;
        if (func_reg == FUNC_FREE) begin
            new_word = word | bit_mask;
        end else begin
            new_word = word & ~bit_mask;
        end
    end

    // word valid and summary bits, result register
    always_comb begin
        vld_next       = vld_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_MOD && out_free) begin
            out_valid_next        = 1'b1;
            out_next.ok           = hit_reg;
            out_next.frame_number = '0;
            if (hit_reg && is_alloc) begin
                out_next.frame_number = FRAME_W'({idx_reg, bit_sel});
            end
            if (ram_wr_en) begin
                vld_next[idx_reg] = 1'b1;
                sum_next[idx_reg] = |new_word;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vld_reg       <= vld_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_data.func;
            page_reg <= s_data.page_number;
        end
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        out_reg <= out_next;
    end

    // map storage
    pfba_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_reg),
        .wr_data (new_word),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_next),
        .rd_data (ram_rd_data)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    // a summary bit is never set for a word that was never written
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_reg & ~vld_reg) == '0)
    else $error("summary bit set for unwritten map word");

    // an allocation hands out a frame whose bit was actually free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD && out_free && hit_reg && is_alloc) |-> word[bit_sel])
    else $error("allocation picked a used frame");

    // a write-back always completes the item with a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |=> (state_reg == ST_IDLE && out_valid_reg))
    else $error("write-back without result");
`endif

endmodule
